// ----- hw/rtl/acmac_pkg.sv -----
// Shared constants, types and functions for the AES-128 CMAC tag block.
// Used by acmac_ram and aes128_cmac_tag.
package acmac_pkg;

   localparam int WORD_W     = 64;
   localparam int RK_DEPTH   = 22;
   localparam int CNT_W      = 5;

   localparam logic [0:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [0:0] CSR_KEY_LOW  = 1'b1;

   localparam logic [7:0] GF128_POLY = 8'h87;
   localparam logic [7:0] PAD_BYTE   = 8'h80;

   typedef logic [127:0] block_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] r;
      case (x)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the block sits at bits [127-8i -: 8]
   function automatic logic [7:0] byte_at(input block_type b, input int i);
      return b[127 - 8 * i -: 8];
   endfunction

   // SubBytes, ShiftRows and, unless last round, MixColumns
   function automatic block_type aes_round(input block_type s, input logic last);
      block_type t;
      block_type o;
      logic [7:0] a0, a1, a2, a3;
      for (int i = 0; i < 16; i++) begin
         t[127 - 8 * i -: 8] = sbox(byte_at(s, (i % 4) + 4 * (((i / 4) + (i % 4)) % 4)));
      end
      for (int c = 0; c < 4; c++) begin
         a0 = byte_at(t, 4 * c);
         a1 = byte_at(t, 4 * c + 1);
         a2 = byte_at(t, 4 * c + 2);
         a3 = byte_at(t, 4 * c + 3);
         o[127 - 32 * c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         o[119 - 32 * c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         o[111 - 32 * c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         o[103 - 32 * c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return last ? t : o;
   endfunction

   // next round key from the previous one
   function automatic block_type key_step(input block_type k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      case (r)
         4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
         4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
         4'd9: v = 8'h1b; 4'd10: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic block_type dbl128(input block_type x);
      return {x[126:0], 1'b0} ^ {120'd0, (x[127] ? GF128_POLY : 8'h00)};
   endfunction

endpackage

// ----- hw/rtl/aes128_cmac_tag.sv -----
// AES-128 CMAC tag generator, top level.
// Depends on acmac_pkg and acmac_ram (round key store).
//
// Usage:
//  - csr_: write key_high (index 0) and key_low (index 1) while idle. Any key
//    write drops the prepared keys and the chain, abandoning a message.
//  - req_: one 128-bit message word per handshake with byte_count and
//    last_block. Words are taken one at a time.
//  - rsp_: one tag word after each last block.
// Sequence: a word runs through load, round key 0 and ten rounds through the
// shared round unit, each round key read from the single-port RAM in the
// state before its use. A last word's tag is registered after the tenth
// round, and the next word is taken once the block is back in idle. The first
// word after reset or a key write first runs key preparation: expanding the
// key into the RAM and encrypting zero for K1/K2.
// Reset clears the key registers, chain, subkeys and the keys-ready flag;
// the round key RAM needs no clearing since it is written before use.
// While a tag is stalled in the output register the block still takes and
// chains non-last words, but stalls a last word until the tag is taken.
module aes128_cmac_tag
   import acmac_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [0:0]        csr_index,
   input  logic [WORD_W-1:0] csr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [WORD_W-1:0] req_block_high,
   input  logic [WORD_W-1:0] req_block_low,
   input  logic [CNT_W-1:0]  req_byte_count,
   input  logic              req_last_block,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_tag_high,
   output logic [WORD_W-1:0] rsp_tag_low
);
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXPAND = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_ROUND  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [3:0]        rnd_ff, rnd_in;
   logic              keys_ready_ff, keys_ready_in;
   logic              subkey_pass_ff, subkey_pass_in;
   logic              last_ff, last_in;
   logic [WORD_W-1:0] key_hi_ff, key_lo_ff;
   block_type         chain_ff, chain_in;
   block_type         k1_ff, k1_in, k2_ff, k2_in;
   block_type         st_ff, st_in;
   block_type         xk_ff, xk_in;
   block_type         msg_ff, msg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              out_v_ff, out_v_in;
   block_type         tag_ff, tag_in;

   logic              ram_we;
   logic [3:0]        ram_addr;
   block_type         ram_wd, ram_rd;
   block_type         din, padded, next_st;
   logic [CNT_W-1:0]  cnt;
   logic              accept, key_wr;

   acmac_ram #(.WIDTH(2 * WORD_W), .DEPTH(RK_DEPTH / 2)) u_rk (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   assign req_stall = (state_ff != ST_IDLE) || (out_v_ff && req_last_block && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign key_wr    = csr_write;
   assign rsp_valid    = out_v_ff;
   assign rsp_tag_high = tag_ff[127:64];
   assign rsp_tag_low  = tag_ff[63:0];

   assign cnt = (req_byte_count > CNT_W'(16)) ? CNT_W'(16) : req_byte_count;

   // CMAC block formatting from the held word, after the subkeys are known
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         if (i < cnt_ff) begin
            padded[127 - 8 * i -: 8] = msg_ff[127 - 8 * i -: 8];
         end else if (i == cnt_ff) begin
            padded[127 - 8 * i -: 8] = PAD_BYTE;
         end else begin
            padded[127 - 8 * i -: 8] = 8'h00;
         end
      end
      if (!last_ff) begin
         din = msg_ff ^ chain_ff;
      end else if (cnt_ff == CNT_W'(16)) begin
         din = msg_ff ^ k1_ff ^ chain_ff;
      end else begin
         din = padded ^ k2_ff ^ chain_ff;
      end
   end

   assign next_st = aes_round(st_ff, rnd_ff == 4'd10) ^ ram_rd;

   always_comb begin
      state_in       = state_ff;
      rnd_in         = rnd_ff;
      keys_ready_in  = keys_ready_ff;
      subkey_pass_in = subkey_pass_ff;
      last_in        = last_ff;
      chain_in       = chain_ff;
      k1_in          = k1_ff;
      k2_in          = k2_ff;
      st_in          = st_ff;
      xk_in          = xk_ff;
      msg_in         = msg_ff;
      cnt_in         = cnt_ff;
      out_v_in       = out_v_ff && rsp_stall;
      tag_in         = tag_ff;
      ram_we         = 1'b0;
      ram_addr       = rnd_ff;
      ram_wd         = xk_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_last_block;
               msg_in  = {req_block_high, req_block_low};
               cnt_in  = cnt;
               if (!keys_ready_ff) begin
                  state_in = ST_EXPAND;
                  rnd_in   = 4'd0;
                  xk_in    = {key_hi_ff, key_lo_ff};
               end else begin
                  subkey_pass_in = 1'b0;
                  state_in = ST_LOAD;
                  rnd_in   = 4'd0;
               end
            end
         end
         ST_EXPAND: begin
            ram_we = 1'b1;
            xk_in  = key_step(xk_ff, rcon(rnd_ff + 4'd1));
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == 4'd10) begin
               state_in       = ST_LOAD;
               rnd_in         = 4'd0;
               subkey_pass_in = 1'b1;
            end
         end
         ST_LOAD: begin
            // read of round key 0 is in flight
            st_in    = subkey_pass_ff ? '0 : din;
            rnd_in   = 4'd1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rnd_ff == 4'd1) begin
               st_in = st_ff ^ ram_rd;
               rnd_in = 4'd1;
               ram_addr = 4'd1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            st_in  = next_st;
            rnd_in = rnd_ff + 4'd1;
            ram_addr = rnd_ff + 4'd1;
            if (rnd_ff == 4'd10) begin
               rnd_in   = 4'd0;
               ram_addr = 4'd0;
               if (subkey_pass_ff) begin
                  k1_in          = dbl128(next_st);
                  k2_in          = dbl128(dbl128(next_st));
                  keys_ready_in  = 1'b1;
                  subkey_pass_in = 1'b0;
                  state_in       = ST_LOAD;
               end else begin
                  state_in = ST_IDLE;
                  if (last_ff) begin
                     chain_in = '0;
                     out_v_in = 1'b1;
                     tag_in   = next_st;
                  end else begin
                     chain_in = next_st;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_IDLE && accept && keys_ready_ff) begin
         ram_addr = 4'd0;
      end
      // a key write drops the prepared keys and the running chain
      if (key_wr) begin
         keys_ready_in = 1'b0;
         chain_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rnd_ff         <= 4'd0;
         keys_ready_ff  <= 1'b0;
         subkey_pass_ff <= 1'b0;
         out_v_ff       <= 1'b0;
         chain_ff       <= '0;
         k1_ff          <= '0;
         k2_ff          <= '0;
         key_hi_ff      <= '0;
         key_lo_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         rnd_ff         <= rnd_in;
         keys_ready_ff  <= keys_ready_in;
         subkey_pass_ff <= subkey_pass_in;
         out_v_ff       <= out_v_in;
         chain_ff       <= chain_in;
         k1_ff          <= k1_in;
         k2_ff          <= k2_in;
         if (key_wr) begin
            if (csr_index == CSR_KEY_HIGH) begin
               key_hi_ff <= csr_data;
            end
            if (csr_index == CSR_KEY_LOW) begin
               key_lo_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff   <= st_in;
      xk_ff   <= xk_in;
      tag_ff  <= tag_in;
      last_ff <= last_in;
      msg_ff  <= msg_in;
      cnt_ff  <= cnt_in;
   end

`ifndef SYNTHESIS
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("word accepted while busy path did not start");
   a_tag_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(tag_ff))
      else $error("stalled tag changed");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (rnd_ff >= 4'd1 && rnd_ff <= 4'd10))
      else $error("round counter out of range");
   a_keys_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && !subkey_pass_ff) |-> keys_ready_ff)
      else $error("message encrypted before keys prepared");
`endif
endmodule

// ----- hw/rtl/acmac_ram.sv -----
// Generic single-port synchronous RAM, registered read.
// Depends on acmac_pkg for the default geometry.
module acmac_ram
   import acmac_pkg::*;
#(
   parameter int WIDTH = 2 * WORD_W,
   parameter int DEPTH = RK_DEPTH / 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
